[rtl/dlfs_pkg.sv]
package dlfs_pkg;

   // fixture geometry
   localparam int unsigned NUM_CHANNELS = 10;
   localparam int unsigned DUTY_MAX     = 215;
   localparam int unsigned SLOT_COUNT   = NUM_CHANNELS + 2;
   localparam int unsigned STROBE_SLOT  = NUM_CHANNELS;
   localparam int unsigned SPEED_SLOT   = NUM_CHANNELS + 1;

   // widths
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int unsigned SLOT_AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int unsigned STEP_W    = 6;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned TMO_W     = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DW    = 16;
   localparam int unsigned COUNT_W   = 7;

   // item actions
   localparam logic [1:0] ACT_SLOT  = 2'd0;
   localparam logic [1:0] ACT_FRAME = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // operating modes (the unused code runs as dmx)
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_DMX    = 2'd1;
   localparam logic [1:0] MODE_MANUAL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd3;

   // register reset values
   localparam logic [1:0]       MODE_RST    = MODE_OFF;
   localparam logic [PCT_W-1:0] PERCENT_RST = 7'd100;
   localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd3000;

   // output stage selection
   localparam logic [1:0] SHOW_ALL  = 2'd0;
   localparam logic [1:0] SHOW_PICK = 2'd1;
   localparam logic [1:0] SHOW_NONE = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [3:0]        slot_index;
      logic [7:0]        slot_value;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] duty_out_0;
      logic [7:0] duty_out_1;
      logic [7:0] duty_out_2;
      logic [7:0] duty_out_3;
      logic [7:0] duty_out_4;
      logic [7:0] duty_out_5;
      logic [7:0] duty_out_6;
      logic [7:0] duty_out_7;
      logic [7:0] duty_out_8;
      logic [7:0] duty_out_9;
      logic       signal_ok;
      logic [7:0] mean_level;
   } rsp_type;

   // per-tick controls for the channel unit
   typedef struct packed {
      logic [1:0]         mode;
      logic               lost;
      logic [LEVEL_W-1:0] speed;
      logic [PCT_W-1:0]   percent;
      logic [1:0]         show_sel;
      logic [CH_W-1:0]    pick;
   } chan_ctrl_type;

endpackage

[rtl/dlfs_ram.sv]
module dlfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dlfs_mod.sv]
module dlfs_mod (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dlfs_pkg::TIME_W-1:0]       value,
   output logic                              done,
   output logic [dlfs_pkg::CH_W-1:0]         rem
);

   localparam int unsigned DIGIT_W = 8;
   localparam int unsigned STEPS   = dlfs_pkg::TIME_W / DIGIT_W;
   localparam int unsigned CNT_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int unsigned R_W     = dlfs_pkg::CH_W;

   logic [dlfs_pkg::TIME_W-1:0] word_ff, word_in;
   logic [R_W-1:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [R_W-1:0]              digit_rem;

   // one byte per cycle, msb first: r = (2r + bit) mod n, bit by bit
   always_comb begin
      logic [R_W:0] t;
      digit_rem = rem_ff;
      for (int b = 0; b < DIGIT_W; b++) begin
         t = {digit_rem, word_ff[dlfs_pkg::TIME_W-1-b]};
         if (t >= (R_W+1)'(dlfs_pkg::NUM_CHANNELS)) begin
            t = t - (R_W+1)'(dlfs_pkg::NUM_CHANNELS);
         end
         digit_rem = t[R_W-1:0];
      end
   end

   // step control
   always_comb begin
      word_in = word_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         word_in = value;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         word_in = word_ff << DIGIT_W;
         rem_in  = digit_rem;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      word_ff <= word_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

[rtl/dlfs_chan.sv]
module dlfs_chan (
   input  dlfs_pkg::chan_ctrl_type            ctrl,
   input  logic [dlfs_pkg::CH_W-1:0]          chan_idx,
   input  logic [dlfs_pkg::LEVEL_W-1:0]       cur_level,
   input  logic [dlfs_pkg::LEVEL_W-1:0]       tgt_level,
   output logic [dlfs_pkg::LEVEL_W-1:0]       new_level,
   output logic [7:0]                         duty
);

   localparam int unsigned LV   = 2 ** dlfs_pkg::LEVEL_W;
   localparam int unsigned PCTS = 2 ** dlfs_pkg::PCT_W;

   logic [7:0]                    duty_lut   [LV];
   logic [dlfs_pkg::LEVEL_W-1:0]  manual_lut [PCTS];
   logic [dlfs_pkg::STEP_W-1:0]   step_lut   [LV];

   logic [dlfs_pkg::STEP_W-1:0]   step;
   logic [dlfs_pkg::LEVEL_W:0]    up_sum;
   logic [dlfs_pkg::LEVEL_W:0]    dn_lim;
   logic [dlfs_pkg::LEVEL_W-1:0]  slew_level;
   logic [dlfs_pkg::LEVEL_W-1:0]  show_level;

   // level to compare value, capped at DUTY_MAX
   for (genvar v = 0; v < LV; v++) begin : g_duty
      localparam int unsigned Q = (254 * v) / dlfs_pkg::DUTY_MAX;
      localparam int unsigned D = (v == 0) ? 0 :
                                  ((Q > dlfs_pkg::DUTY_MAX) ? dlfs_pkg::DUTY_MAX : Q);
      assign duty_lut[v] = 8'(D);
   end

   // percent to level, saturating
   for (genvar v = 0; v < PCTS; v++) begin : g_manual
      localparam int unsigned M = (v * 255) / 100;
      localparam int unsigned S = (M > 255) ? 255 : M;
      assign manual_lut[v] = dlfs_pkg::LEVEL_W'(S);
   end

   // fade speed to per-tick step
   for (genvar v = 0; v < LV; v++) begin : g_step
      localparam int unsigned W = (v == 0) ? 0 : (260 - v) / 5;
      assign step_lut[v] = dlfs_pkg::STEP_W'(W);
   end

   // slew toward the target, stopping at it
   always_comb begin
      step       = step_lut[ctrl.speed];
      up_sum     = {1'b0, cur_level} + {{(dlfs_pkg::LEVEL_W+1-dlfs_pkg::STEP_W){1'b0}}, step};
      dn_lim     = {1'b0, tgt_level} + {{(dlfs_pkg::LEVEL_W+1-dlfs_pkg::STEP_W){1'b0}}, step};
      slew_level = cur_level;
      if (cur_level < tgt_level) begin
         slew_level = (up_sum > {1'b0, tgt_level}) ? tgt_level : up_sum[dlfs_pkg::LEVEL_W-1:0];
      end else if (cur_level > tgt_level) begin
         if ({1'b0, cur_level} < dn_lim) begin
            slew_level = tgt_level;
         end else begin
            slew_level = cur_level - dlfs_pkg::LEVEL_W'(step);
         end
      end
   end

   // new level by mode
   always_comb begin
      case (ctrl.mode)
         dlfs_pkg::MODE_OFF: begin
            new_level = '0;
         end
         dlfs_pkg::MODE_MANUAL: begin
            new_level = manual_lut[ctrl.percent];
         end
         default: begin
            if (ctrl.lost) begin
               new_level = '0;
            end else if (ctrl.speed == '0) begin
               new_level = tgt_level;
            end else begin
               new_level = slew_level;
            end
         end
      endcase
   end

   // strobe gating and duty lookup
   always_comb begin
      case (ctrl.show_sel)
         dlfs_pkg::SHOW_ALL: begin
            show_level = new_level;
         end
         dlfs_pkg::SHOW_PICK: begin
            show_level = (chan_idx == ctrl.pick) ? new_level : '0;
         end
         default: begin
            show_level = '0;
         end
      endcase
      duty = duty_lut[show_level];
   end

endmodule

[rtl/dmx_led_dimmer_fade_strobe_unit.sv]
// a tick accepted in idle reads the strobe and speed slots, waits for the
// byte-serial modulo of time_ms, then does one level-memory read-modify-write per
// channel; its result waits while the result register is still occupied, and no
// new beat (tick, slot write or frame mark) is accepted until the block is idle again
// reset: synchronous, active high; registers return to their defaults and the
// slot and level memories read as zero until written (per-entry valid bits)
module dmx_led_dimmer_fade_strobe_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dlfs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dlfs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [dlfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dlfs_pkg::CSR_DW-1:0]         csr_wdata
);

   localparam int unsigned N       = dlfs_pkg::NUM_CHANNELS;
   localparam int unsigned CH_W    = dlfs_pkg::CH_W;
   localparam int unsigned SLOT_AW = dlfs_pkg::SLOT_AW;
   localparam int unsigned LW      = dlfs_pkg::LEVEL_W;
   localparam int unsigned SUM_W   = $clog2(N * 255 + 1);
   localparam int unsigned MEAN_SH = 20;
   localparam int unsigned MEAN_RC = (2 ** MEAN_SH + N - 1) / N;
   localparam int unsigned RC_W    = MEAN_SH + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SPEED = 3'd1;
   localparam logic [2:0] ST_PREP  = 3'd2;
   localparam logic [2:0] ST_LOOP  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // configuration
   logic [1:0]                    mode_ff;
   logic [dlfs_pkg::PCT_W-1:0]    percent_ff;
   logic                          invert_ff;
   logic [dlfs_pkg::TMO_W-1:0]    timeout_ff;

   // sequencer and scalar state
   logic [2:0]                    state_ff, state_in;
   logic [CH_W-1:0]               idx_ff, idx_in;
   logic [dlfs_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [dlfs_pkg::TIME_W-1:0]   last_frame_ff, last_frame_in;
   logic [dlfs_pkg::COUNT_W-1:0]  strobe_count_ff, strobe_count_in;
   logic                          signal_flag_ff, signal_flag_in;
   logic                          lost_ff, lost_in;
   logic [LW-1:0]                 strobe_ff, strobe_in;
   logic [LW-1:0]                 speed_ff, speed_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [7:0]                    duty_work_ff [N];
   logic                          rsp_valid_ff, rsp_valid_in;
   dlfs_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // memory ports and valid bits
   logic [dlfs_pkg::SLOT_COUNT-1:0] slot_valid_ff, slot_valid_in;
   logic [N-1:0]                  lvl_valid_ff, lvl_valid_in;
   logic                          slot_rvalid_ff, lvl_rvalid_ff;
   logic                          slot_we, slot_re, lvl_we, lvl_re;
   logic [SLOT_AW-1:0]            slot_waddr, slot_raddr;
   logic [CH_W-1:0]               lvl_raddr;
   logic [LW-1:0]                 slot_rdata, lvl_rdata;
   logic [LW-1:0]                 slot_word, lvl_word;

   // handshake and helpers
   logic                          req_acc, tick_acc, last_ch, is_dmx, rsp_load;
   logic [CH_W-1:0]               idx_next, out_idx;
   logic                          mod_done;
   logic [CH_W-1:0]               mod_rem;
   dlfs_pkg::chan_ctrl_type       ctrl;
   logic [LW-1:0]                 new_level;
   logic [7:0]                    duty;
   logic [LW-1:0]                 strobe_eff;
   logic [LW-1:0]                 full_thr, rnd_thr;
   logic [1:0]                    show_sel;
   logic [SUM_W+RC_W-1:0]         mean_prod;

   assign req_acc  = req_valid && req_ready;
   assign tick_acc = req_acc && (req_data.action == dlfs_pkg::ACT_TICK);
   assign req_ready = (state_ff == ST_IDLE);
   assign last_ch  = (idx_ff == CH_W'(N - 1));
   assign idx_next = idx_ff + 1'b1;
   assign is_dmx   = (mode_ff != dlfs_pkg::MODE_OFF) && (mode_ff != dlfs_pkg::MODE_MANUAL);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= dlfs_pkg::MODE_RST;
         percent_ff <= dlfs_pkg::PERCENT_RST;
         invert_ff  <= 1'b0;
         timeout_ff <= dlfs_pkg::TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dlfs_pkg::CSR_MODE:    mode_ff    <= csr_wdata[1:0];
            dlfs_pkg::CSR_PERCENT: percent_ff <= csr_wdata[dlfs_pkg::PCT_W-1:0];
            dlfs_pkg::CSR_INVERT:  invert_ff  <= csr_wdata[0];
            dlfs_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata[dlfs_pkg::TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // slot store: written by slot beats, read for strobe, speed and targets
   always_comb begin
      slot_we    = req_acc && (req_data.action == dlfs_pkg::ACT_SLOT) &&
                   (req_data.slot_index != 4'd0) &&
                   ({1'b0, req_data.slot_index} <= 5'(dlfs_pkg::SLOT_COUNT));
      slot_waddr = SLOT_AW'(req_data.slot_index - 4'd1);
      slot_re    = 1'b0;
      slot_raddr = '0;
      lvl_re     = 1'b0;
      lvl_raddr  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            slot_re    = tick_acc;
            slot_raddr = SLOT_AW'(dlfs_pkg::STROBE_SLOT);
         end
         ST_SPEED: begin
            slot_re    = 1'b1;
            slot_raddr = SLOT_AW'(dlfs_pkg::SPEED_SLOT);
         end
         ST_PREP: begin
            slot_re = mod_done;
            lvl_re  = mod_done;
         end
         ST_LOOP: begin
            slot_re    = !last_ch;
            lvl_re     = !last_ch;
            slot_raddr = SLOT_AW'(idx_next);
            lvl_raddr  = idx_next;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   dlfs_ram #(
      .WIDTH (LW),
      .DEPTH (dlfs_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (req_data.slot_value),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   assign lvl_we = (state_ff == ST_LOOP);

   dlfs_ram #(
      .WIDTH (LW),
      .DEPTH (N)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (idx_ff),
      .wr_data (new_level),
      .rd_en   (lvl_re),
      .rd_addr (lvl_raddr),
      .rd_data (lvl_rdata)
   );

   // valid bits: never-written entries read as zero
   always_comb begin
      slot_valid_in = slot_valid_ff;
      lvl_valid_in  = lvl_valid_ff;
      if (slot_we) begin
         slot_valid_in[slot_waddr] = 1'b1;
      end
      if (lvl_we) begin
         lvl_valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff  <= '0;
         lvl_valid_ff   <= '0;
         slot_rvalid_ff <= 1'b0;
         lvl_rvalid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         lvl_valid_ff  <= lvl_valid_in;
         if (slot_re) begin
            slot_rvalid_ff <= slot_valid_ff[slot_raddr];
         end
         if (lvl_re) begin
            lvl_rvalid_ff <= lvl_valid_ff[lvl_raddr];
         end
      end
   end

   assign slot_word = slot_rvalid_ff ? slot_rdata : '0;
   assign lvl_word  = lvl_rvalid_ff ? lvl_rdata : '0;

   // time_ms mod channel count for the random strobe pick
   dlfs_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (tick_acc),
      .value (req_data.time_ms),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // strobe decision for this tick
   always_comb begin
      strobe_eff = (is_dmx && !lost_ff) ? strobe_ff : '0;
      full_thr   = (8'd129 - strobe_eff) >> 1;
      rnd_thr    = (8'd255 - strobe_eff) >> 1;
      if (strobe_eff == '0) begin
         show_sel = dlfs_pkg::SHOW_ALL;
      end else if (!strobe_eff[LW-1]) begin
         show_sel = ({1'b0, strobe_count_ff} >= full_thr) ? dlfs_pkg::SHOW_ALL
                                                         : dlfs_pkg::SHOW_NONE;
      end else begin
         show_sel = ({1'b0, strobe_count_ff} >= rnd_thr) ? dlfs_pkg::SHOW_PICK
                                                        : dlfs_pkg::SHOW_NONE;
      end
      ctrl.mode     = mode_ff;
      ctrl.lost     = lost_ff;
      ctrl.speed    = speed_ff;
      ctrl.percent  = percent_ff;
      ctrl.show_sel = show_sel;
      ctrl.pick     = mod_rem;
   end

   dlfs_chan u_chan (
      .ctrl      (ctrl),
      .chan_idx  (idx_ff),
      .cur_level (lvl_word),
      .tgt_level (slot_word),
      .new_level (new_level),
      .duty      (duty)
   );

   assign out_idx   = invert_ff ? (CH_W'(N - 1) - idx_ff) : idx_ff;
   assign mean_prod = (SUM_W+RC_W)'(sum_ff) * (SUM_W+RC_W)'(MEAN_RC);

   // tick sequencer
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      now_in          = now_ff;
      last_frame_in   = last_frame_ff;
      strobe_count_in = strobe_count_ff;
      signal_flag_in  = signal_flag_ff;
      lost_in         = lost_ff;
      strobe_in       = strobe_ff;
      speed_in        = speed_ff;
      sum_in          = sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.action == dlfs_pkg::ACT_FRAME)) begin
               last_frame_in = req_data.time_ms;
            end
            if (tick_acc) begin
               now_in   = req_data.time_ms;
               sum_in   = '0;
               idx_in   = '0;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            strobe_in = slot_word;
            lost_in   = now_ff > (last_frame_ff +
                                  {{(dlfs_pkg::TIME_W-dlfs_pkg::TMO_W){1'b0}}, timeout_ff});
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            speed_in = slot_word;
            if (mod_done) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            sum_in = sum_ff + SUM_W'(lvl_word);
            idx_in = idx_next;
            if (last_ch) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               if (is_dmx) begin
                  signal_flag_in = !lost_ff;
               end
               if (show_sel == dlfs_pkg::SHOW_NONE) begin
                  if (strobe_count_ff != '1) begin
                     strobe_count_in = strobe_count_ff + 1'b1;
                  end
               end else begin
                  strobe_count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat assembly
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_data_in.duty_out_0 = duty_work_ff[0];
         rsp_data_in.duty_out_1 = duty_work_ff[1];
         rsp_data_in.duty_out_2 = duty_work_ff[2];
         rsp_data_in.duty_out_3 = duty_work_ff[3];
         rsp_data_in.duty_out_4 = duty_work_ff[4];
         rsp_data_in.duty_out_5 = duty_work_ff[5];
         rsp_data_in.duty_out_6 = duty_work_ff[6];
         rsp_data_in.duty_out_7 = duty_work_ff[7];
         rsp_data_in.duty_out_8 = duty_work_ff[8];
         rsp_data_in.duty_out_9 = duty_work_ff[9];
         rsp_data_in.signal_ok  = signal_flag_in;
         rsp_data_in.mean_level = mean_prod[MEAN_SH +: 8];
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         last_frame_ff   <= '0;
         strobe_count_ff <= '0;
         signal_flag_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         last_frame_ff   <= last_frame_in;
         strobe_count_ff <= strobe_count_in;
         signal_flag_ff  <= signal_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      now_ff      <= now_in;
      lost_ff     <= lost_in;
      strobe_ff   <= strobe_in;
      speed_ff    <= speed_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_LOOP) begin
         duty_work_ff[out_idx] <= duty;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // channel walk starts only once the pick is known
   a_loop_after_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> mod_done)
      else $error("channel walk running before modulo finished");

   // walk index stays inside the channel range
   a_loop_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> (idx_ff <= CH_W'(N - 1)))
      else $error("channel index out of range");

   // signal flag rises only when a dmx tick completes
   a_flag_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(signal_flag_ff) |-> ($past(state_ff) == ST_DONE) &&
                                ($past(mode_ff) != dlfs_pkg::MODE_OFF) &&
                                ($past(mode_ff) != dlfs_pkg::MODE_MANUAL))
      else $error("signal flag set outside a dmx tick");

   // strobe pacing only moves at the end of a tick
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |=> $stable(strobe_count_ff))
      else $error("strobe count changed mid-tick");

endmodule

[tb/dimmer_duty_checker.sv]
module dimmer_duty_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  dlfs_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  dlfs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [dlfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dlfs_pkg::CSR_DW-1:0]         csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding
);
   import dlfs_pkg::*;

   // fixture copy: slot bytes, channel levels, frame stamp, strobe pacing
   logic [7:0]        slot_bytes [SLOT_COUNT];
   logic [7:0]        chan_lvl   [NUM_CHANNELS];
   logic [TIME_W-1:0] frame_stamp;
   logic [6:0]        pause_count;
   logic              sig_ok;

   // register copy
   logic [1:0]        cfg_mode;
   logic [PCT_W-1:0]  cfg_pct;
   logic              cfg_inv;
   logic [TMO_W-1:0]  cfg_tmo;

   // duty frames owed by the block, oldest first
   rsp_type           duty_frames_due [$];
   rsp_type           got_frame;
   rsp_type           want_frame;

   // one printed line per mismatch, capped so a broken block stays readable
   task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch %s: want %0d got %0d at %0t", what, want_v, got_v, $realtime);
   endtask

   function automatic logic [7:0] duty_of_level(input logic [7:0] lvl);
      int unsigned d;
      if (lvl == 8'd0)
         return 8'd0;
      d = 254 * lvl / DUTY_MAX;
      if (d > DUTY_MAX)
         d = DUTY_MAX;
      return 8'(d);
   endfunction

   function automatic logic [7:0] duty_field(input rsp_type r, input int p);
      case (p)
         0: return r.duty_out_0;
         1: return r.duty_out_1;
         2: return r.duty_out_2;
         3: return r.duty_out_3;
         4: return r.duty_out_4;
         5: return r.duty_out_5;
         6: return r.duty_out_6;
         7: return r.duty_out_7;
         8: return r.duty_out_8;
         default: return r.duty_out_9;
      endcase
   endfunction

   // one update tick: new levels, strobe stage, output order, mean of old levels
   task automatic advance_levels(input req_type r);
      int unsigned       sum;
      int unsigned       m;
      int unsigned       stp;
      int unsigned       cur;
      int unsigned       tgt;
      int unsigned       strobe;
      int unsigned       full_rate;
      int unsigned       pick_rate;
      int unsigned       pick;
      logic [TIME_W-1:0] deadline;
      logic [7:0]        shown [NUM_CHANNELS];
      logic [7:0]        duty  [NUM_CHANNELS];
      logic [7:0]        mean;
      rsp_type           want;

      sum = 0;
      foreach (chan_lvl[i])
         sum += chan_lvl[i];
      mean = 8'(sum / NUM_CHANNELS);
      strobe = 0;
      full_rate = 0;
      pick_rate = 0;
      deadline = frame_stamp + {16'd0, cfg_tmo};

      // level update per mode
      if (cfg_mode == MODE_OFF) begin
         foreach (chan_lvl[i])
            chan_lvl[i] = 8'd0;
      end else if (cfg_mode == MODE_MANUAL) begin
         m = cfg_pct * 255 / 100;
         if (m > 255)
            m = 255;
         foreach (chan_lvl[i])
            chan_lvl[i] = 8'(m);
      end else if (r.time_ms > deadline) begin
         foreach (chan_lvl[i])
            chan_lvl[i] = 8'd0;
         sig_ok = 1'b0;
      end else begin
         strobe = slot_bytes[STROBE_SLOT];
         if (slot_bytes[SPEED_SLOT] == 8'd0) begin
            foreach (chan_lvl[i])
               chan_lvl[i] = slot_bytes[i];
         end else begin
            stp = (260 - slot_bytes[SPEED_SLOT]) / 5;
            foreach (chan_lvl[i]) begin
               cur = chan_lvl[i];
               tgt = slot_bytes[i];
               if (cur < tgt)
                  cur = (cur + stp > tgt) ? tgt : cur + stp;
               else if (cur > tgt)
                  cur = (cur < tgt + stp) ? tgt : cur - stp;
               chan_lvl[i] = 8'(cur);
            end
         end
         if (strobe > 127)
            pick_rate = strobe - 127;
         else
            full_rate = strobe;
         sig_ok = 1'b1;
      end

      // strobe stage
      if (strobe == 0) begin
         foreach (shown[i])
            shown[i] = chan_lvl[i];
         pause_count = 7'd0;
      end else if (full_rate > 0 && pause_count >= (129 - full_rate) / 2) begin
         foreach (shown[i])
            shown[i] = chan_lvl[i];
         pause_count = 7'd0;
      end else if (pick_rate > 0 && pause_count >= (128 - pick_rate) / 2) begin
         pick = r.time_ms % NUM_CHANNELS;
         foreach (shown[i])
            shown[i] = (i == pick) ? chan_lvl[i] : 8'd0;
         pause_count = 7'd0;
      end else begin
         foreach (shown[i])
            shown[i] = 8'd0;
         if (pause_count < 7'd127)
            pause_count++;
      end

      // output order and duty mapping
      foreach (duty[p])
         duty[p] = duty_of_level(shown[cfg_inv ? NUM_CHANNELS - 1 - p : p]);
      want = {duty[0], duty[1], duty[2], duty[3], duty[4], duty[5], duty[6], duty[7],
              duty[8], duty[9], sig_ok, mean};
      duty_frames_due.push_back(want);
   endtask

   // watch the ports at every edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (slot_bytes[i])
            slot_bytes[i] = 8'd0;
         foreach (chan_lvl[i])
            chan_lvl[i] = 8'd0;
         frame_stamp = '0;
         pause_count = 7'd0;
         sig_ok = 1'b0;
         cfg_mode = MODE_RST;
         cfg_pct = PERCENT_RST;
         cfg_inv = 1'b0;
         cfg_tmo = TIMEOUT_RST;
         duty_frames_due.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE:    cfg_mode = csr_wdata[1:0];
               CSR_PERCENT: cfg_pct = csr_wdata[PCT_W-1:0];
               CSR_INVERT:  cfg_inv = csr_wdata[0];
               CSR_TIMEOUT: cfg_tmo = csr_wdata[TMO_W-1:0];
               default: ;
            endcase
         end

         // accepted input beat
         if (req_valid && req_ready) begin
            case (req_data.action)
               ACT_SLOT: begin
                  if (req_data.slot_index >= 1 && req_data.slot_index <= SLOT_COUNT)
                     slot_bytes[req_data.slot_index - 1] = req_data.slot_value;
               end
               ACT_FRAME: frame_stamp = req_data.time_ms;
               ACT_TICK:  advance_levels(req_data);
               default: ;
            endcase
         end

         // accepted result beat
         if (rsp_valid && rsp_ready) begin
            got_frame = rsp_data;
            if (duty_frames_due.size() == 0) begin
               flag_mismatch("result beat with nothing due", 0, 1);
            end else begin
               want_frame = duty_frames_due.pop_front();
               for (int p = 0; p < NUM_CHANNELS; p++) begin
                  if (duty_field(got_frame, p) !== duty_field(want_frame, p))
                     flag_mismatch($sformatf("duty_out_%0d", p), duty_field(want_frame, p),
                                   duty_field(got_frame, p));
               end
               if (got_frame.signal_ok !== want_frame.signal_ok)
                  flag_mismatch("signal_ok", want_frame.signal_ok, got_frame.signal_ok);
               if (got_frame.mean_level !== want_frame.mean_level)
                  flag_mismatch("mean_level", want_frame.mean_level, got_frame.mean_level);
            end
         end
      end
      outstanding <= duty_frames_due.size();
   end

endmodule

[tb/dmx_led_dimmer_fade_strobe_unit_test.sv]
module dmx_led_dimmer_fade_strobe_unit_test;
   import dlfs_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] ACT_SPARE  = 2'd3;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DW-1:0]    csr_wdata;
   int                   mismatches;
   int                   outstanding;

   logic [TIME_W-1:0]    now_ms;
   bit                   calm;
   int                   hold_ask;
   int                   hold_seen;

   dmx_led_dimmer_fade_strobe_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dimmer_duty_checker duty_watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: random stalls, plus one long hold when asked
   initial begin
      rsp_ready = 1'b0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 14);
         end
      end
   end

   // offer one beat, with random idle cycles ahead of it
   task automatic offer(input logic [1:0] act, input logic [3:0] idx,
                        input logic [7:0] val, input logic [TIME_W-1:0] stamp);
      req_type beat;
      beat.action = act;
      beat.slot_index = idx;
      beat.slot_value = val;
      beat.time_ms = stamp;
      if (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 14);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering until every result is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers once the block is idle
   task automatic program_fixture(input logic [1:0] md, input logic [PCT_W-1:0] pct,
                                  input logic inv, input logic [TMO_W-1:0] tmo);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= CSR_DW'(md);
      @(posedge clock);
      csr_index <= CSR_PERCENT;
      csr_wdata <= CSR_DW'(pct);
      @(posedge clock);
      csr_index <= CSR_INVERT;
      csr_wdata <= CSR_DW'(inv);
      @(posedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= CSR_DW'(tmo);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly frame / slot writes / tick bursts, some noise and time jumps
   task automatic random_phase(input int unsigned items);
      int unsigned done;
      int unsigned roll;
      int unsigned pick;
      logic [3:0]  idx;
      logic [7:0]  val;
      done = 0;
      while (done < items) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            // ignored beats
            if (roll[0])
               offer(ACT_SPARE, 4'($urandom), 8'($urandom), $urandom);
            else
               offer(ACT_SLOT, ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(13, 15)),
                     8'($urandom), $urandom);
         end else if (roll < 14) begin
            // long silence, often past the timeout
            now_ms += $urandom_range(0, 70000);
            offer(ACT_TICK, 4'($urandom), 8'($urandom), now_ms);
            done++;
         end else begin
            if ($urandom_range(3) != 0) begin
               offer(ACT_FRAME, 4'($urandom), 8'($urandom), now_ms);
               done++;
            end
            repeat ($urandom_range(0, 4)) begin
               idx = 4'($urandom_range(1, SLOT_COUNT));
               pick = $urandom_range(9);
               if (idx == STROBE_SLOT + 1) begin
                  // strobe slot: off half the time, else short or random pacing
                  case (pick)
                     5: val = 8'($urandom_range(1, 127));
                     6: val = 8'($urandom_range(128, 255));
                     7: val = 8'($urandom_range(118, 127));
                     8: val = 8'($urandom_range(245, 255));
                     9: val = 8'hFF;
                     default: val = 8'd0;
                  endcase
               end else begin
                  val = (pick < 3) ? 8'd0 : (pick < 4) ? 8'hFF : 8'($urandom);
               end
               offer(ACT_SLOT, idx, val, $urandom);
               done++;
            end
            repeat ($urandom_range(1, 8)) begin
               now_ms += $urandom_range(0, 3);
               offer(ACT_TICK, 4'($urandom), 8'($urandom), now_ms);
               done++;
            end
         end
      end
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      hold_ask = 0;
      now_ms = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // off mode after reset, ignored slot indexes and the unused action
      offer(ACT_TICK, 4'd0, 8'd0, 32'd0);
      offer(ACT_SLOT, 4'd0, 8'hFF, 32'd0);
      offer(ACT_SLOT, 4'd15, 8'hFF, 32'hFFFF_FFFF);
      offer(ACT_SPARE, 4'hF, 8'hFF, 32'hFFFF_FFFF);

      // dmx: jump, slow and fast slew, full and random strobe, timeout
      program_fixture(MODE_DMX, 7'd100, 1'b0, 16'd3000);
      offer(ACT_FRAME, 4'd0, 8'd0, 32'd1000);
      offer(ACT_SLOT, 4'd1, 8'hFF, 32'd0);
      offer(ACT_SLOT, 4'd10, 8'd1, 32'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1000);
      offer(ACT_SLOT, 4'd12, 8'hFF, 32'd0);
      offer(ACT_SLOT, 4'd1, 8'd0, 32'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1001);
      offer(ACT_SLOT, 4'd12, 8'd1, 32'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1002);
      offer(ACT_SLOT, 4'd11, 8'd127, 32'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1003);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1004);
      offer(ACT_SLOT, 4'd11, 8'hFF, 32'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1009);
      offer(ACT_SLOT, 4'd11, 8'd128, 32'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd1010);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd4000);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd4001);
      // deadline that wraps past the top of the time range
      offer(ACT_FRAME, 4'd0, 8'd0, 32'hFFFF_FF00);
      offer(ACT_TICK, 4'd0, 8'd0, 32'hFFFF_FFFF);

      // manual overflow with reversed order, then the unused mode
      program_fixture(MODE_MANUAL, 7'd127, 1'b1, 16'd0);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd7);
      program_fixture(MODE_SPARE, 7'd0, 1'b0, 16'hFFFF);
      offer(ACT_FRAME, 4'd0, 8'd0, 32'd5);
      offer(ACT_TICK, 4'd0, 8'd0, 32'd5);

      // output side holds off while ticks keep coming
      program_fixture(MODE_DMX, 7'd50, 1'b0, 16'd3000);
      now_ms = $urandom;
      hold_ask <= hold_ask + 1;
      random_phase(250);

      // no idling on either side
      program_fixture(MODE_DMX, 7'd100, 1'b1, 16'hFFFF);
      calm <= 1'b1;
      random_phase(200);
      calm <= 1'b0;

      program_fixture(MODE_SPARE, 7'd0, 1'b0, 16'd0);
      random_phase(150);

      program_fixture(MODE_MANUAL, 7'd100, 1'b1, 16'($urandom));
      random_phase(120);

      program_fixture(MODE_MANUAL, 7'd0, 1'($urandom), 16'($urandom));
      random_phase(80);

      program_fixture(MODE_OFF, 7'($urandom_range(0, 127)), 1'b1, 16'd3000);
      random_phase(80);

      // time near the wrap point
      program_fixture(MODE_DMX, 7'($urandom_range(0, 100)), 1'($urandom), 16'($urandom));
      now_ms = 32'hFFFF_F000;
      random_phase(300);

      // short timeouts
      program_fixture(MODE_DMX, 7'($urandom_range(0, 100)), 1'($urandom),
                      16'($urandom_range(0, 400)));
      now_ms = $urandom;
      random_phase(300);

      settle();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
